// ===== rtl/kt_pkg.sv =====
// shared constants and control types for the kendall tau-b correlator
package kt_pkg;

   localparam int MAX_SAMPLES   = 1024;
   localparam int SAMPLE_BITS   = 32;
   localparam int TAU_FRAC_BITS = 14;

   localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int TOTAL_BITS  = 20;
   localparam int FIELD_BITS  = 19;
   localparam int TAU_BITS    = 16;
   localparam int USED_BITS   = 11;
   localparam int REQ_BITS    = 2 * SAMPLE_BITS;
   localparam int RSP_FIELDS  = 4 * FIELD_BITS + TAU_BITS + USED_BITS;
   localparam int RSP_BITS    = ((RSP_FIELDS + 7) / 8) * 8;

   localparam logic [TOTAL_BITS-1:0] COUNT_MAX = TOTAL_BITS'((1 << FIELD_BITS) - 1);

   typedef struct packed {
      logic load_item;
      logic scan_rd;
      logic drain;
      logic mark_over;
      logic tau_start;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic scan_end;
      logic last;
      logic rsp_free;
      logic tau_done;
   } ctrl_status_type;

endpackage

// ===== rtl/kt_ctrl.sv =====
// controller state machine sequencing scan, store, tau and result load
module kt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tlast,
   output logic                     req_tready,
   input  kt_pkg::ctrl_status_type  status,
   output kt_pkg::ctrl_cmd_type     cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_TSTART = 3'd3;
   localparam logic [2:0] S_TWAIT  = 3'd4;
   localparam logic [2:0] S_TLOAD  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               if (status.full) begin
                  cmd.mark_over = 1'b1;
                  state_in = req_tlast ? S_TSTART : S_IDLE;
               end else if (status.empty) begin
                  state_in = S_DRAIN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_end) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.drain = 1'b1;
            state_in  = status.last ? S_TSTART : S_IDLE;
         end
         S_TSTART: begin
            cmd.tau_start = 1'b1;
            state_in      = S_TWAIT;
         end
         S_TWAIT: begin
            if (status.tau_done) state_in = S_TLOAD;
         end
         S_TLOAD: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/kt_tau.sv =====
// iterative tau-b unit: bit-by-bit root of a scaled ratio with split multiplies
module kt_tau (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [kt_pkg::TOTAL_BITS-1:0]     conc,
   input  logic [kt_pkg::TOTAL_BITS-1:0]     disc,
   input  logic [kt_pkg::TOTAL_BITS-1:0]     tie_u,
   input  logic [kt_pkg::TOTAL_BITS-1:0]     tie_v,
   output logic                              done,
   output logic signed [kt_pkg::TAU_BITS-1:0] tau_fixed,
   output logic                              tau_valid
);

   localparam int H_BITS    = kt_pkg::TOTAL_BITS + 1;
   localparam int P_BITS    = 2 * H_BITS;
   localparam int Q_BITS    = kt_pkg::TAU_FRAC_BITS + 1;
   localparam int TT_BITS   = 2 * Q_BITS;
   localparam int PP_BITS   = TT_BITS + H_BITS;
   localparam int PROD_BITS = TT_BITS + P_BITS;
   localparam int NUM_BITS  = 2 * kt_pkg::TOTAL_BITS;
   localparam int SHIFT     = 2 * kt_pkg::TAU_FRAC_BITS;
   localparam int BIT_BITS  = $clog2(Q_BITS);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_SETUP = 3'd1;
   localparam logic [2:0] T_SQ    = 3'd2;
   localparam logic [2:0] T_LO    = 3'd3;
   localparam logic [2:0] T_HI    = 3'd4;
   localparam logic [2:0] T_CMP   = 3'd5;
   localparam logic [2:0] T_DONE  = 3'd6;

   logic [2:0]                    phase_ff, phase_in;
   logic [H_BITS-1:0]             h1_ff, h2_ff;
   logic [kt_pkg::TOTAL_BITS-1:0] mag_ff;
   logic                          neg_ff;
   logic [P_BITS-1:0]             p_ff;
   logic [NUM_BITS-1:0]           num_ff;
   logic [Q_BITS-1:0]             q_ff;
   logic [BIT_BITS-1:0]           bit_ff;
   logic [TT_BITS-1:0]            tt_ff;
   logic [PP_BITS-1:0]            plo_ff, phi_ff;
   logic [Q_BITS-1:0]             trial;
   logic [PROD_BITS-1:0]          prod, target;
   logic [H_BITS-1:0]             cd;
   logic [Q_BITS:0]               mag_q;

   assign trial  = q_ff | (Q_BITS'(1) << bit_ff);
   assign prod   = {phi_ff, {H_BITS{1'b0}}} + PROD_BITS'(plo_ff);
   assign target = PROD_BITS'({num_ff, {SHIFT{1'b0}}});
   assign cd     = H_BITS'(conc) + H_BITS'(disc);

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         T_IDLE:  if (start) phase_in = T_SETUP;
         T_SETUP: phase_in = T_SQ;
         T_SQ:    phase_in = T_LO;
         T_LO:    phase_in = T_HI;
         T_HI:    phase_in = T_CMP;
         T_CMP:   phase_in = (bit_ff == '0) ? T_DONE : T_SQ;
         T_DONE:  phase_in = T_IDLE;
         default: phase_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= T_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         T_IDLE: begin
            if (start) begin
               h1_ff  <= cd + H_BITS'(tie_v);
               h2_ff  <= cd + H_BITS'(tie_u);
               neg_ff <= disc > conc;
               mag_ff <= (disc > conc) ? disc - conc : conc - disc;
            end
         end
         T_SETUP: begin
            p_ff   <= P_BITS'(h1_ff) * P_BITS'(h2_ff);
            num_ff <= NUM_BITS'(mag_ff) * NUM_BITS'(mag_ff);
            q_ff   <= '0;
            bit_ff <= BIT_BITS'(kt_pkg::TAU_FRAC_BITS);
         end
         T_SQ: tt_ff  <= TT_BITS'(trial) * TT_BITS'(trial);
         T_LO: plo_ff <= PP_BITS'(tt_ff) * PP_BITS'(p_ff[H_BITS-1:0]);
         T_HI: phi_ff <= PP_BITS'(tt_ff) * PP_BITS'(p_ff[P_BITS-1:H_BITS]);
         T_CMP: begin
            if (prod <= target) q_ff <= trial;
            if (bit_ff != '0) bit_ff <= bit_ff - 1'b1;
         end
         default: ;
      endcase
   end

   assign done      = (phase_ff == T_DONE);
   assign tau_valid = (h1_ff != '0) && (h2_ff != '0);
   assign mag_q     = {1'b0, q_ff};
   assign tau_fixed = !tau_valid ? '0 :
                      neg_ff ? kt_pkg::TAU_BITS'(-mag_q) : kt_pkg::TAU_BITS'(mag_q);

endmodule

// ===== rtl/kt_dpath.sv =====
// datapath: sample store, shared comparator, pair counts and result register
module kt_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [kt_pkg::REQ_BITS-1:0]       req_tdata,
   input  logic                              req_tlast,
   input  kt_pkg::ctrl_cmd_type              cmd,
   output kt_pkg::ctrl_status_type           status,
   input  logic                              tau_done,
   input  logic signed [kt_pkg::TAU_BITS-1:0] tau_fixed,
   input  logic                              tau_valid,
   output logic [kt_pkg::TOTAL_BITS-1:0]     conc,
   output logic [kt_pkg::TOTAL_BITS-1:0]     disc,
   output logic [kt_pkg::TOTAL_BITS-1:0]     tie_u,
   output logic [kt_pkg::TOTAL_BITS-1:0]     tie_v,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kt_pkg::RSP_BITS-1:0]       rsp_tdata,
   output logic [1:0]                        rsp_tuser
);

   localparam int SB = kt_pkg::SAMPLE_BITS;
   localparam int AB = kt_pkg::ADDR_BITS;
   localparam int CB = kt_pkg::COUNT_BITS;
   localparam int TB = kt_pkg::TOTAL_BITS;
   localparam int FB = kt_pkg::FIELD_BITS;

   logic signed [SB-1:0] mem_u [kt_pkg::MAX_SAMPLES];
   logic signed [SB-1:0] mem_v [kt_pkg::MAX_SAMPLES];
   logic signed [SB-1:0] rdu_ff, rdv_ff, u_ff, v_ff;
   logic                 last_ff, over_ff, rd_valid_ff;
   logic [CB-1:0]        count_ff;
   logic [AB-1:0]        scan_ff;
   logic [TB-1:0]        conc_ff, disc_ff, tie_u_ff, tie_v_ff;
   logic                 rsp_valid_ff;
   logic [kt_pkg::RSP_BITS-1:0] rsp_data_ff;
   logic [1:0]           rsp_user_ff;
   logic                 eq_u, eq_v, gt_u, gt_v;

   function automatic logic [FB-1:0] sat_field(input logic [TB-1:0] x);
      return (x > kt_pkg::COUNT_MAX) ? FB'(kt_pkg::COUNT_MAX) : x[FB-1:0];
   endfunction

   // sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.drain) begin
         mem_u[count_ff[AB-1:0]] <= u_ff;
         mem_v[count_ff[AB-1:0]] <= v_ff;
      end
      rdu_ff <= mem_u[scan_ff];
      rdv_ff <= mem_v[scan_ff];
   end

   assign eq_u = (u_ff == rdu_ff);
   assign eq_v = (v_ff == rdv_ff);
   assign gt_u = (u_ff > rdu_ff);
   assign gt_v = (v_ff > rdv_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         u_ff    <= req_tdata[SB-1:0];
         v_ff    <= req_tdata[2*SB-1:SB];
         last_ff <= req_tlast;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= kt_pkg::RSP_BITS'({kt_pkg::USED_BITS'(count_ff), tau_fixed,
                                           sat_field(tie_v_ff), sat_field(tie_u_ff),
                                           sat_field(disc_ff), sat_field(conc_ff)});
         rsp_user_ff <= {over_ff, tau_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         over_ff      <= 1'b0;
         conc_ff      <= '0;
         disc_ff      <= '0;
         tie_u_ff     <= '0;
         tie_v_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_rd;
         if (cmd.load_item) scan_ff <= '0;
         else if (cmd.scan_rd) scan_ff <= scan_ff + 1'b1;
         if (cmd.mark_over) over_ff <= 1'b1;
         if (rd_valid_ff && !(eq_u && eq_v)) begin
            if (eq_u) tie_u_ff <= tie_u_ff + 1'b1;
            else if (eq_v) tie_v_ff <= tie_v_ff + 1'b1;
            else if (gt_u == gt_v) conc_ff <= conc_ff + 1'b1;
            else disc_ff <= disc_ff + 1'b1;
         end
         if (cmd.drain) count_ff <= count_ff + 1'b1;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         // result loaded: the run starts over
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= '0;
            over_ff      <= 1'b0;
            conc_ff      <= '0;
            disc_ff      <= '0;
            tie_u_ff     <= '0;
            tie_v_ff     <= '0;
         end
      end
   end

   assign status.full     = (count_ff == CB'(kt_pkg::MAX_SAMPLES));
   assign status.empty    = (count_ff == '0);
   assign status.scan_end = ((CB'(scan_ff) + 1'b1) == count_ff);
   assign status.last     = last_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;
   assign status.tau_done = tau_done;

   assign conc       = conc_ff;
   assign disc       = disc_ff;
   assign tie_u      = tie_u_ff;
   assign tie_v      = tie_v_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(kt_pkg::MAX_SAMPLES))
      else $error("pair count past capacity");

   a_store_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.drain |-> !status.full)
      else $error("store written while full");

   a_read_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(cmd.scan_rd))
      else $error("compare without a read");

endmodule

// ===== rtl/kendall_tau_b_correlator.sv =====
// top level of the kendall tau-b correlator
// Each pair is compared against the pairs already stored in the run through one memory read
// port and one comparator; no new pair is accepted until its scan and store are done, and a
// pair arriving with the store full is not stored. The last pair of a run adds the tau unit,
// which finds 15 quotient bits one at a time (square, two split multiplies, compare) after
// setup, then the result waits in an output register while the next run's pairs are accepted.
// The store needs no clearing after reset: only entries written in the current run are read.
module kendall_tau_b_correlator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kt_pkg::REQ_BITS-1:0]   req_tdata,  // sample_u, sample_v
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // concordant_pairs, discordant_pairs, ties_u_only, ties_v_only, tau_fixed, pairs_used
   output logic [kt_pkg::RSP_BITS-1:0]   rsp_tdata,
   output logic [1:0]                    rsp_tuser   // tau_valid, run_overflow
);

   kt_pkg::ctrl_cmd_type              cmd;
   kt_pkg::ctrl_status_type           status;
   logic                              tau_done, tau_valid;
   logic signed [kt_pkg::TAU_BITS-1:0] tau_fixed;
   logic [kt_pkg::TOTAL_BITS-1:0]     conc, disc, tie_u, tie_v;

   kt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kt_tau u_tau (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.tau_start),
      .conc      (conc),
      .disc      (disc),
      .tie_u     (tie_u),
      .tie_v     (tie_v),
      .done      (tau_done),
      .tau_fixed (tau_fixed),
      .tau_valid (tau_valid)
   );

   kt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .tau_done   (tau_done),
      .tau_fixed  (tau_fixed),
      .tau_valid  (tau_valid),
      .conc       (conc),
      .disc       (disc),
      .tie_u      (tie_u),
      .tie_v      (tie_v),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
